/* hdl/sdld_pkg.sv */
// shared constants and stage record for the signed decimal long divider
package sdld_pkg;

    localparam int OpWidth    = 16;
    localparam int MagWidth   = OpWidth;
    localparam int DigitCount = 4;
    localparam int DigitWidth = 4;
    localparam int CountWidth = 3;
    localparam int RemWidth   = MagWidth + 4;

    typedef struct packed {
        logic                  valid;
        logic                  negative;
        logic                  zero_div;
        logic [MagWidth-1:0]   divisor;
        logic [RemWidth-1:0]   rem;
        logic [MagWidth-1:0]   quotient;
        logic [CountWidth-1:0] count;
        logic [DigitCount*DigitWidth-1:0] digits;
    } stage_t;

endpackage

/* hdl/sdld_digit_stage.sv */
// one decimal fraction digit step: remainder times ten over divisor
module sdld_digit_stage
    import sdld_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   [CountWidth-1:0] slot,
    input  stage_t in_stage,
    output stage_t out_stage
);

    stage_t                out_reg;
    stage_t                out_next;
    logic [RemWidth-1:0]   t;
    logic [RemWidth-1:0]   r;
    logic [DigitWidth-1:0] d;
    logic [RemWidth-1:0]   dv;

    // ten compare and subtract steps are too many: restoring over four bits
    always_comb
    begin
        out_next = in_stage;
        t  = (in_stage.rem << 3) + (in_stage.rem << 1);
        dv = {{(RemWidth-MagWidth){1'b0}}, in_stage.divisor};
        r  = t;
        d  = '0;
        for (int k = DigitWidth - 1; k >= 0; k--)
        begin
            if (r >= (dv << k))
            begin
                r = r - (dv << k);
                d[k] = 1'b1;
            end
        end
        if (in_stage.rem != '0)
        begin
            out_next.rem   = r;
            out_next.count = in_stage.count + 1'b1;
            out_next.digits[(DigitCount-1-slot)*DigitWidth +: DigitWidth] = d;
        end
    end

    // only the valid bit is reset, the data bits simply follow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg.valid <= 1'b0;
        else
            out_reg <= out_next;
    end

    assign out_stage = out_reg;

endmodule

/* hdl/signed_decimal_long_divider.sv */
// top level of the signed decimal long divider
// Pipelined signed divider with four decimal fraction digits. A transfer is
// taken whenever start is high; busy is always low, so one item may enter
// every cycle. The result appears with done high for exactly one cycle
// and cannot be held off: stage one forms the magnitudes, sixteen stages
// each resolve one quotient bit by compare and subtract, and four stages
// each produce one decimal digit.
// A zero divisor gives divide_error with every other field zero.
module signed_decimal_long_divider
    import sdld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OpWidth-1:0]    dividend,
    input  logic [OpWidth-1:0]    divisor,
    output logic                  done,
    output logic                  negative,
    output logic [MagWidth-1:0]   quotient_magnitude,
    output logic [CountWidth-1:0] digit_count,
    output logic [DigitWidth-1:0] digit_first,
    output logic [DigitWidth-1:0] digit_second,
    output logic [DigitWidth-1:0] digit_third,
    output logic [DigitWidth-1:0] digit_fourth,
    output logic                  divide_error
);

    stage_t in_reg;
    stage_t in_next;
    stage_t q_reg [MagWidth+1];
    stage_t d_st  [DigitCount+1];
    logic [MagWidth-1:0] mag_a;
    logic [MagWidth-1:0] mag_b;

    assign busy = 1'b0;

    // magnitudes and sign; dividend rides in the quotient field
    always_comb
    begin
        mag_a = dividend[OpWidth-1] ? (~dividend + 1'b1) : dividend;
        mag_b = divisor[OpWidth-1]  ? (~divisor + 1'b1)  : divisor;
        in_next          = '0;
        in_next.valid    = start;
        in_next.negative = dividend[OpWidth-1] ^ divisor[OpWidth-1];
        in_next.zero_div = (divisor == '0);
        in_next.divisor  = mag_b;
        in_next.quotient = mag_a;
    end

    // only the valid bit is reset, the data bits simply follow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg.valid <= 1'b0;
        else
            in_reg <= in_next;
    end

    assign q_reg[0] = in_reg;

    // restoring division, one quotient bit per stage, msb first
    for (genvar i = 0; i < MagWidth; i++)
    begin : g_qbit
        stage_t              s_reg;
        stage_t              s_next;
        logic [RemWidth-1:0] trial;

        always_comb
        begin
            s_next = q_reg[i];
            trial  = {q_reg[i].rem[RemWidth-2:0], q_reg[i].quotient[MagWidth-1]};
            s_next.quotient = {q_reg[i].quotient[MagWidth-2:0], 1'b0};
            if (trial >= {{(RemWidth-MagWidth){1'b0}}, q_reg[i].divisor})
            begin
                s_next.rem = trial - {{(RemWidth-MagWidth){1'b0}}, q_reg[i].divisor};
                s_next.quotient[0] = 1'b1;
            end
            else
                s_next.rem = trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_reg.valid <= 1'b0;
            else
                s_reg <= s_next;
        end

        assign q_reg[i+1] = s_reg;
    end

    // zero divisor leaves a zero remainder so no digits are formed
    always_comb
    begin
        d_st[0] = q_reg[MagWidth];
        if (q_reg[MagWidth].zero_div)
            d_st[0].rem = '0;
    end

    for (genvar j = 0; j < DigitCount; j++)
    begin : g_digit
        sdld_digit_stage u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .slot      (CountWidth'(j)),
            .in_stage  (d_st[j]),
            .out_stage (d_st[j+1])
        );
    end

    // error forces the sign, quotient magnitude and digit count to zero
    always_comb
    begin
        done               = d_st[DigitCount].valid;
        divide_error       = d_st[DigitCount].zero_div;
        negative           = d_st[DigitCount].negative & ~divide_error;
        quotient_magnitude = divide_error ? '0 : d_st[DigitCount].quotient;
        digit_count        = divide_error ? '0 : d_st[DigitCount].count;
        digit_first        = d_st[DigitCount].digits[4*DigitWidth-1 -: DigitWidth];
        digit_second       = d_st[DigitCount].digits[3*DigitWidth-1 -: DigitWidth];
        digit_third        = d_st[DigitCount].digits[2*DigitWidth-1 -: DigitWidth];
        digit_fourth       = d_st[DigitCount].digits[DigitWidth-1 -: DigitWidth];
    end

endmodule
